FILE: sv/gfc_pkg.sv
`timescale 1ns / 1ps
// Package for the greedy first-fit vertex colorer.
// Holds the sizes, command codes, sequencer states and RAM port bundles.
package gfc_pkg;

  localparam int VERTS  = 1024;
  localparam int EDGES  = 8192;

  localparam int CMD_W  = 3;
  localparam int ADDR_W = 13;
  localparam int VAL_W  = 14;
  localparam int VID_W  = $clog2(VERTS);
  localparam int COL_W  = $clog2(VERTS + 1);
  localparam int OFF_W  = VAL_W;
  localparam int OFF_AW = $clog2(VERTS + 1);
  localparam int NBR_AW = $clog2(EDGES);

  localparam logic [CMD_W-1:0] CMD_WR_OFF = CMD_W'(0);
  localparam logic [CMD_W-1:0] CMD_WR_NBR = CMD_W'(1);
  localparam logic [CMD_W-1:0] CMD_WR_COL = CMD_W'(2);
  localparam logic [CMD_W-1:0] CMD_COLOUR = CMD_W'(3);
  localparam logic [CMD_W-1:0] CMD_RD_COL = CMD_W'(4);
  localparam logic [CMD_W-1:0] CMD_CLEAR  = CMD_W'(5);

  localparam logic [COL_W-1:0] UNCOLOURED = COL_W'(VERTS);
  localparam logic [COL_W-1:0] MARK_EMPTY = '1;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_SWEEP = 11'b000_0000_0010,
    S_OFF1  = 11'b000_0000_0100,
    S_OFF2  = 11'b000_0000_1000,
    S_NBR   = 11'b000_0001_0000,
    S_COL   = 11'b000_0010_0000,
    S_MARK  = 11'b000_0100_0000,
    S_SRCH0 = 11'b000_1000_0000,
    S_SRCH  = 11'b001_0000_0000,
    S_RDCOL = 11'b010_0000_0000,
    S_SPARE = 11'b100_0000_0000
  } state_t;

  typedef struct packed {
    logic              we;
    logic [OFF_AW-1:0] waddr;
    logic [OFF_W-1:0]  wdata;
    logic [OFF_AW-1:0] raddr;
  } off_port_t;

  typedef struct packed {
    logic              we;
    logic [NBR_AW-1:0] waddr;
    logic [VID_W-1:0]  wdata;
    logic [NBR_AW-1:0] raddr;
  } nbr_port_t;

  typedef struct packed {
    logic             we;
    logic [VID_W-1:0] waddr;
    logic [COL_W-1:0] wdata;
    logic [VID_W-1:0] raddr;
  } vmem_port_t;

endpackage

FILE: sv/gfc_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/gfc_seq.sv
`timescale 1ns / 1ps
// Command sequencer: decodes commands, walks neighbours, stamps marks and
// searches for the first free colour with one shared compare. Uses gfc_pkg.
module gfc_seq
  import gfc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [CMD_W-1:0]  command,
  input  logic [ADDR_W-1:0] address,
  input  logic [VAL_W-1:0]  value,
  output logic              valid,
  output logic [VID_W-1:0]  vertex,
  output logic [COL_W-1:0]  colour,
  output off_port_t         off_port,
  output nbr_port_t         nbr_port,
  output vmem_port_t        col_port,
  output vmem_port_t        mark_port,
  input  logic [OFF_W-1:0]  off_rdata,
  input  logic [VID_W-1:0]  nbr_rdata,
  input  logic [COL_W-1:0]  col_rdata,
  input  logic [COL_W-1:0]  mark_rdata
);

  localparam logic [ADDR_W:0]  VERTS_A  = (ADDR_W + 1)'(VERTS);
  localparam logic [ADDR_W:0]  EDGES_A  = (ADDR_W + 1)'(EDGES);
  localparam logic [VAL_W-1:0] VERTS_V  = VAL_W'(VERTS);
  localparam logic [OFF_W-1:0] EDGES_O  = OFF_W'(EDGES);
  localparam logic [VID_W-1:0] LAST_VID = VID_W'(VERTS - 1);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(VERTS - 1);

  state_t           state, state_next;
  logic [VID_W-1:0] v;
  logic [OFF_W-1:0] e;
  logic [OFF_W-1:0] stop;
  logic [COL_W-1:0] c;
  logic [VID_W-1:0] sw;
  logic             sweep_col;

  logic             accept;
  logic             addr_is_vert;
  logic [OFF_W-1:0] stop_clip;
  logic [COL_W-1:0] c_inc;
  logic             found;
  logic             last;
  logic [COL_W-1:0] res_col;

  assign busy         = (state != S_IDLE);
  assign accept       = start && !busy;
  assign addr_is_vert = ({1'b0, address} < VERTS_A);
  assign stop_clip    = (off_rdata > EDGES_O) ? EDGES_O : off_rdata;
  assign c_inc        = c + COL_W'(1);
  assign found        = (mark_rdata != {1'b0, v});
  assign last         = (c == LAST_COL);
  assign res_col      = found ? c : UNCOLOURED;

  always_comb begin
    state_next = state;

    off_port.we    = 1'b0;
    off_port.waddr = address[OFF_AW-1:0];
    off_port.wdata = value;
    off_port.raddr = (state == S_OFF1) ? ({1'b0, v} + OFF_AW'(1)) : address[OFF_AW-1:0];

    nbr_port.we    = 1'b0;
    nbr_port.waddr = address[NBR_AW-1:0];
    nbr_port.wdata = value[VID_W-1:0];
    nbr_port.raddr = e[NBR_AW-1:0];

    col_port.we    = 1'b0;
    col_port.waddr = address[VID_W-1:0];
    col_port.wdata = (value > VERTS_V) ? UNCOLOURED : value[COL_W-1:0];
    col_port.raddr = (state == S_COL) ? nbr_rdata : address[VID_W-1:0];

    mark_port.we    = 1'b0;
    mark_port.waddr = col_rdata[VID_W-1:0];
    mark_port.wdata = {1'b0, v};
    mark_port.raddr = (state == S_SRCH) ? c_inc[VID_W-1:0] : '0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (command)
            CMD_WR_OFF: off_port.we = ({1'b0, address} <= VERTS_A);
            CMD_WR_NBR: nbr_port.we = ({1'b0, address} < EDGES_A) && (value < VERTS_V);
            CMD_WR_COL: col_port.we = addr_is_vert;
            CMD_COLOUR: if (addr_is_vert) state_next = S_OFF1;
            CMD_RD_COL: if (addr_is_vert) state_next = S_RDCOL;
            CMD_CLEAR:  state_next = S_SWEEP;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_SWEEP: begin
        mark_port.we    = 1'b1;
        mark_port.waddr = sw;
        mark_port.wdata = MARK_EMPTY;
        col_port.we     = sweep_col;
        col_port.waddr  = sw;
        col_port.wdata  = UNCOLOURED;
        if (sw == LAST_VID) state_next = S_IDLE;
      end
      S_OFF1: state_next = S_OFF2;
      S_OFF2: state_next = (e < stop_clip) ? S_NBR : S_SRCH0;
      S_NBR:  state_next = S_COL;
      S_COL:  state_next = S_MARK;
      S_MARK: begin
        mark_port.we = (col_rdata < UNCOLOURED);
        state_next   = (e < stop) ? S_COL : S_SRCH0;
      end
      S_SRCH0: state_next = S_SRCH;
      S_SRCH: begin
        if (found || last) begin
          col_port.we    = 1'b1;
          col_port.waddr = v;
          col_port.wdata = res_col;
          state_next     = S_IDLE;
        end
      end
      S_RDCOL: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SWEEP;
      sweep_col <= 1'b1;
      sw        <= '0;
      valid     <= 1'b0;
    end else begin
      state <= state_next;
      valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            v <= address[VID_W-1:0];
            if (command == CMD_CLEAR) begin
              sweep_col <= 1'b0;
              sw        <= '0;
            end
          end
        end
        S_SWEEP: sw <= sw + VID_W'(1);
        S_OFF1:  e <= off_rdata;
        S_OFF2:  stop <= stop_clip;
        S_COL:   e <= e + OFF_W'(1);
        S_SRCH0: c <= '0;
        S_SRCH: begin
          c <= c_inc;
          if (found || last) begin
            valid  <= 1'b1;
            vertex <= v;
            colour <= res_col;
          end
        end
        S_RDCOL: begin
          valid  <= 1'b1;
          vertex <= v;
          colour <= col_rdata;
        end
        default: ;
      endcase
    end
  end

  a_valid_src: assert property (@(posedge clk) disable iff (rst)
    valid |-> ($past(state) == S_SRCH || $past(state) == S_RDCOL))
    else $error("result strobe without search or read");

  a_colour_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> (colour <= UNCOLOURED))
    else $error("reported colour out of range");

  a_colour_start: assert property (@(posedge clk) disable iff (rst)
    (accept && command == CMD_COLOUR && addr_is_vert) |=> (state == S_OFF1))
    else $error("colour command did not start offset fetch");

  a_mark_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mark_port.we)
    else $error("mark write while idle");

endmodule

FILE: sv/greedy_first_fit_vertex_colorer.sv
`timescale 1ns / 1ps
// Greedy first-fit vertex colorer over a CSR graph: top level with the
// offset, neighbour, colour and mark RAMs. Uses gfc_pkg, gfc_ram, gfc_seq.
//
// A word is accepted when start is high and busy is low. Colour vertex
// makes two offset reads, a neighbour read, a colour read then a mark stamp
// per neighbour, a search setup step, then a mark scan of one colour per
// cycle, all through the single read port of each RAM. The scan stops at
// the first free colour c, or after all 1024 colours when every colour is
// taken. The result is strobed by valid in the first cycle with busy low
// again. Clear marks and the sweep after reset write one entry per cycle
// with busy high. The result shows for exactly one cycle on valid; the
// receiver cannot stall.
module greedy_first_fit_vertex_colorer
  import gfc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [CMD_W-1:0]  command,
  input  logic [ADDR_W-1:0] address,
  input  logic [VAL_W-1:0]  value,
  output logic              valid,
  output logic [VID_W-1:0]  vertex,
  output logic [COL_W-1:0]  colour
);

  off_port_t        off_port;
  nbr_port_t        nbr_port;
  vmem_port_t       col_port;
  vmem_port_t       mark_port;
  logic [OFF_W-1:0] off_rdata;
  logic [VID_W-1:0] nbr_rdata;
  logic [COL_W-1:0] col_rdata;
  logic [COL_W-1:0] mark_rdata;

  gfc_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .command    (command),
    .address    (address),
    .value      (value),
    .valid      (valid),
    .vertex     (vertex),
    .colour     (colour),
    .off_port   (off_port),
    .nbr_port   (nbr_port),
    .col_port   (col_port),
    .mark_port  (mark_port),
    .off_rdata  (off_rdata),
    .nbr_rdata  (nbr_rdata),
    .col_rdata  (col_rdata),
    .mark_rdata (mark_rdata)
  );

  gfc_ram #(.WIDTH(OFF_W), .DEPTH(VERTS + 1)) u_off_ram (
    .clk   (clk),
    .we    (off_port.we),
    .waddr (off_port.waddr),
    .wdata (off_port.wdata),
    .raddr (off_port.raddr),
    .rdata (off_rdata)
  );

  gfc_ram #(.WIDTH(VID_W), .DEPTH(EDGES)) u_nbr_ram (
    .clk   (clk),
    .we    (nbr_port.we),
    .waddr (nbr_port.waddr),
    .wdata (nbr_port.wdata),
    .raddr (nbr_port.raddr),
    .rdata (nbr_rdata)
  );

  gfc_ram #(.WIDTH(COL_W), .DEPTH(VERTS)) u_col_ram (
    .clk   (clk),
    .we    (col_port.we),
    .waddr (col_port.waddr),
    .wdata (col_port.wdata),
    .raddr (col_port.raddr),
    .rdata (col_rdata)
  );

  gfc_ram #(.WIDTH(COL_W), .DEPTH(VERTS)) u_mark_ram (
    .clk   (clk),
    .we    (mark_port.we),
    .waddr (mark_port.waddr),
    .wdata (mark_port.wdata),
    .raddr (mark_port.raddr),
    .rdata (mark_rdata)
  );

endmodule

FILE: test/tb_greedy_first_fit_vertex_colorer.sv
`timescale 1ns / 1ps
// Self-checking testbench for greedy_first_fit_vertex_colorer: directed corners,
// a full-palette run and random CSR graphs, checked against a first-fit predictor.
// Depends on gfc_pkg and the greedy_first_fit_vertex_colorer top level.
module tb_greedy_first_fit_vertex_colorer;
  import gfc_pkg::*;

  localparam logic [CMD_W-1:0] CMD_RSVD6 = CMD_W'(6);
  localparam logic [CMD_W-1:0] CMD_RSVD7 = CMD_W'(7);
  localparam int LIMIT = 3_000_000;
  localparam int RANDOM_WORDS = 330;
  localparam int PALETTE_V = 700;

  typedef struct {
    logic [VID_W-1:0] vertex;
    logic [COL_W-1:0] colour;
  } colour_word_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [CMD_W-1:0]  command;
  logic [ADDR_W-1:0] address;
  logic [VAL_W-1:0]  value;
  logic              valid;
  logic [VID_W-1:0]  vertex;
  logic [COL_W-1:0]  colour;

  // predictor state
  logic [OFF_W-1:0] off_mem   [VERTS+1];
  bit               off_wr    [VERTS+1];
  logic [VID_W-1:0] nbr_mem   [EDGES];
  bit               nbr_wr    [EDGES];
  logic [COL_W-1:0] col_mem   [VERTS];
  logic [COL_W-1:0] stamp_mem [VERTS];

  colour_word_t colours_due[$];
  int           mismatches;
  int           words_taken;
  bit           no_gaps;

  greedy_first_fit_vertex_colorer u_top (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .command (command),
    .address (address),
    .value   (value),
    .valid   (valid),
    .vertex  (vertex),
    .colour  (colour)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [COL_W-1:0] first_fit(int v);
    int lo, hi, e, c;
    logic [COL_W-1:0] nc;
    lo = int'(off_mem[v]);
    hi = int'(off_mem[v+1]);
    if (hi > EDGES) hi = EDGES;
    for (e = lo; e < hi; e++) begin
      nc = col_mem[nbr_mem[e]];
      if (nc < UNCOLOURED) stamp_mem[nc] = COL_W'(v);
    end
    c = 0;
    while (c < VERTS && stamp_mem[c] == COL_W'(v)) c++;
    col_mem[v] = COL_W'(c);
    return COL_W'(c);
  endfunction

  // true when colouring v reads only written offset and neighbour entries
  function automatic bit can_colour(int v);
    int lo, hi, e;
    if (!off_wr[v] || !off_wr[v+1]) return 1'b0;
    lo = int'(off_mem[v]);
    hi = int'(off_mem[v+1]);
    if (hi > EDGES) hi = EDGES;
    for (e = lo; e < hi; e++)
      if (!nbr_wr[e]) return 1'b0;
    return 1'b1;
  endfunction

  // returns 1 when the word has an effect
  function automatic bit predict(logic [CMD_W-1:0] cmd, int a, int v);
    colour_word_t w;
    case (cmd)
      CMD_WR_OFF: if (a <= VERTS) begin
        off_mem[a] = OFF_W'(v);
        off_wr[a] = 1'b1;
        return 1'b1;
      end
      CMD_WR_NBR: if (a < EDGES && v < VERTS) begin
        nbr_mem[a] = VID_W'(v);
        nbr_wr[a] = 1'b1;
        return 1'b1;
      end
      CMD_WR_COL: if (a < VERTS) begin
        col_mem[a] = (v > VERTS) ? UNCOLOURED : COL_W'(v);
        return 1'b1;
      end
      CMD_COLOUR: if (a < VERTS) begin
        w.vertex = VID_W'(a);
        w.colour = first_fit(a);
        colours_due.push_back(w);
        return 1'b1;
      end
      CMD_RD_COL: if (a < VERTS) begin
        w.vertex = VID_W'(a);
        w.colour = col_mem[a];
        colours_due.push_back(w);
        return 1'b1;
      end
      CMD_CLEAR: begin
        foreach (stamp_mem[i]) stamp_mem[i] = MARK_EMPTY;
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  task automatic send_word(logic [CMD_W-1:0] cmd, int a, int v);
    int gap;
    gap = (!no_gaps && $urandom_range(0, 99) < 25) ? $urandom_range(1, 2) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    command <= cmd;
    address <= ADDR_W'(a);
    value   <= VAL_W'(v);
    @(posedge clk);
    while (busy) @(posedge clk);
    if (predict(cmd, a, v)) words_taken++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (colours_due.size() != 0) @(posedge clk);
  endtask

  task automatic flag_mismatch(bit have_exp, colour_word_t e);
    mismatches++;
    if (mismatches <= 10) begin
      if (have_exp)
        $display("%0t: mismatch: vertex exp %0d got %0d, colour exp %0d got %0d",
                 $realtime, e.vertex, vertex, e.colour, colour);
      else
        $display("%0t: unexpected word: vertex %0d colour %0d", $realtime, vertex, colour);
    end
  endtask

  always @(posedge clk) begin : check_words
    colour_word_t e;
    if (!rst && valid) begin
      if (colours_due.size() == 0) begin
        e.vertex = '0;
        e.colour = '0;
        flag_mismatch(1'b0, e);
      end else begin
        e = colours_due.pop_front();
        if (vertex !== e.vertex || colour !== e.colour) flag_mismatch(1'b1, e);
      end
    end
  end

  task automatic test_loads_and_corners();
    send_word(CMD_WR_OFF, 0, 0);
    send_word(CMD_WR_OFF, 1, 3);
    send_word(CMD_WR_OFF, 2, 5);
    send_word(CMD_WR_OFF, 3, 5);           // vertex 2 has an empty range
    send_word(CMD_WR_OFF, 4, 2);           // vertex 3 ends below its start
    send_word(CMD_WR_OFF, VERTS + 1, 0);   // past the offset table
    send_word(CMD_WR_NBR, 0, 1);
    send_word(CMD_WR_NBR, 1, 0);           // self-loop
    send_word(CMD_WR_NBR, 2, VERTS - 1);
    send_word(CMD_WR_NBR, 3, 0);
    send_word(CMD_WR_NBR, 4, 16383);       // bad id, dropped
    send_word(CMD_WR_NBR, 4, 2);
    send_word(CMD_WR_COL, 1, 16383);       // clamps to uncoloured
    send_word(CMD_WR_COL, 8191, 5);        // bad vertex, dropped
    send_word(CMD_COLOUR, 0, 0);
    send_word(CMD_COLOUR, 0, 0);           // marks its own colour
    send_word(CMD_COLOUR, 1, 0);
    send_word(CMD_COLOUR, 2, 0);
    send_word(CMD_COLOUR, 3, 0);
    send_word(CMD_WR_COL, VERTS - 1, VERTS - 1);
    send_word(CMD_RD_COL, VERTS - 1, 0);
    send_word(CMD_RD_COL, 1, 0);
    send_word(CMD_COLOUR, 8191, 16383);
    send_word(CMD_RD_COL, VERTS, 0);
    send_word(CMD_RSVD6, 0, 0);
    send_word(CMD_RSVD7, 8191, 16383);
    send_word(CMD_CLEAR, 0, 0);
    send_word(CMD_WR_OFF, 5, EDGES - 2);
    send_word(CMD_WR_OFF, 6, 16383);       // range runs past the neighbour table
    send_word(CMD_WR_NBR, EDGES - 2, 0);
    send_word(CMD_WR_NBR, EDGES - 1, 1);
    send_word(CMD_COLOUR, 5, 0);
  endtask

  // self-loop vertex recoloured until every colour carries its mark
  task automatic test_full_palette();
    int k;
    send_word(CMD_CLEAR, 0, 0);
    send_word(CMD_WR_OFF, PALETTE_V, 100);
    send_word(CMD_WR_OFF, PALETTE_V + 1, 101);
    send_word(CMD_WR_NBR, 100, PALETTE_V);
    send_word(CMD_WR_COL, PALETTE_V, VERTS);
    for (k = 0; k <= VERTS + 1; k++)
      send_word(CMD_COLOUR, PALETTE_V, $urandom_range(0, 16383));
    send_word(CMD_CLEAR, 0, 0);
  endtask

  task automatic send_graph_burst();
    int n, b, slot, i, j, d, r, v;
    n = $urandom_range(2, 10);
    b = $urandom_range(0, VERTS - 1 - n);
    slot = $urandom_range(0, EDGES - 1);
    for (i = 0; i <= n; i++) begin
      send_word(CMD_WR_OFF, b + i, slot);
      if (i < n) begin
        d = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 40) : $urandom_range(0, 5);
        for (j = 0; j < d; j++) begin
          v = ($urandom_range(0, 4) != 0) ? b + $urandom_range(0, n - 1)
                                          : $urandom_range(0, VERTS - 1);
          if (slot < EDGES) send_word(CMD_WR_NBR, slot, v);
          slot++;
        end
      end
    end
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 2) == 0) begin
        r = $urandom_range(0, 9);
        v = (r < 5) ? VERTS : (r < 8) ? $urandom_range(0, 7) : $urandom_range(0, 16383);
        send_word(CMD_WR_COL, b + i, v);
      end
    end
    for (i = 0; i < n + $urandom_range(0, 3); i++) begin
      send_word(CMD_COLOUR, b + $urandom_range(0, n - 1), $urandom_range(0, 16383));
      if ($urandom_range(0, 3) == 0)
        send_word(CMD_RD_COL, b + $urandom_range(0, n), $urandom_range(0, 16383));
    end
  endtask

  task automatic send_noise(int count);
    int i, a, v;
    logic [CMD_W-1:0] cmd;
    for (i = 0; i < count; i++) begin
      cmd = CMD_W'($urandom_range(0, 7));
      a = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 8191) : $urandom_range(0, VERTS);
      v = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16383) : $urandom_range(0, VERTS);
      if (cmd == CMD_CLEAR && $urandom_range(0, 3) != 0) cmd = CMD_RD_COL;
      if (cmd == CMD_COLOUR && a < VERTS && !can_colour(a)) cmd = CMD_RD_COL;
      send_word(cmd, a, v);
    end
  endtask

  task automatic test_random_graphs();
    int taken0, r;
    taken0 = words_taken;
    while (words_taken - taken0 < RANDOM_WORDS) begin
      no_gaps = (words_taken - taken0 >= 100 && words_taken - taken0 < 200);
      r = $urandom_range(0, 99);
      if (r < 2) send_word(CMD_CLEAR, $urandom_range(0, 8191), $urandom_range(0, 16383));
      else if (r < 6) drain_results();
      else if (r < 70) send_graph_burst();
      else send_noise($urandom_range(1, 6));
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst     = 1'b1;
    start   = 1'b0;
    command = CMD_WR_OFF;
    address = '0;
    value   = '0;
    no_gaps = 1'b0;
    mismatches = 0;
    words_taken = 0;
    foreach (col_mem[i]) col_mem[i] = UNCOLOURED;
    foreach (stamp_mem[i]) stamp_mem[i] = MARK_EMPTY;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_loads_and_corners();
    drain_results();
    test_full_palette();
    drain_results();
    test_random_graphs();
    drain_results();
    repeat (2100) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
